[hw/rtl/erc_pkg.sv]
// ----------------------------------------------------------------------------
// erc_pkg
// Shared constants, register indexes and the sine series table for the
// euler rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z  = 3'd5;

  // binary angles, a full turn is 2^16
  localparam int ANGLE_W = 16;

  // coefficient slots: cos and sin per axis
  localparam int TRIG_N = 6;
  localparam logic [2:0] TRIG_COS_X = 3'd0;
  localparam logic [2:0] TRIG_SIN_X = 3'd1;
  localparam logic [2:0] TRIG_COS_Y = 3'd2;
  localparam logic [2:0] TRIG_SIN_Y = 3'd3;
  localparam logic [2:0] TRIG_COS_Z = 3'd4;
  localparam logic [2:0] TRIG_SIN_Z = 3'd5;

  // guard bits on the rotated offsets: one for the center subtract and one
  // per rotation
  localparam int GUARD_BITS = 4;

  // sine series constants, Q30
  localparam logic [30:0] Q30_ONE   = 31'd1073741824;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [14:0] QUARTER   = 15'd16384;
  localparam int          DIV_STEPS = 6;

  // horner divisors of the odd series, highest term first:
  // 156, 110, 72, 42, 20, 6, each split into a power of two and an odd part
  // q = ((x >> pre) * magic) >> post, exact for any 32-bit x
  function automatic logic [1:0] horner_pre_sh(input logic [2:0] k);
    logic [1:0] s;
    case (k)
      3'd0: s = 2'd2;
      3'd1: s = 2'd1;
      3'd2: s = 2'd3;
      3'd3: s = 2'd1;
      3'd4: s = 2'd2;
      3'd5: s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  // ceil(2^post / odd part)
  function automatic logic [31:0] horner_magic(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0: m = 32'd1762037866;
      3'd1: m = 32'd2498890064;
      3'd2: m = 32'd954437177;
      3'd3: m = 32'd3272356036;
      3'd4: m = 32'd1717986919;
      3'd5: m = 32'd2863311531;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_post_sh(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0: s = 6'd36;
      3'd1: s = 6'd37;
      3'd2: s = 6'd33;
      3'd3: s = 6'd36;
      3'd4: s = 6'd33;
      3'd5: s = 6'd33;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/euler_rotation_about_center.sv]
// ----------------------------------------------------------------------------
// euler_rotation_about_center
// Rotates a stream of vertices about a configured center, x then y then z.
// ----------------------------------------------------------------------------
// One vertex enters per clock while in_stall is low: a first register
// subtracts the center, each of the three axis rotations has a multiply
// register and a round register, and the output register adds the center
// back and saturates. Stalls on the output back up through the stages
// without losing or repeating items, and empty stages are filled while the
// output waits. Center writes take effect at once. An angle write starts a
// sequencer that evaluates its cosine and sine with one shared multiplier,
// doing the series divisions by reciprocal multiplication; writes to several
// angles queue up, and the input stalls until all are done.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotation_about_center
  import erc_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_in,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_in,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x_out,
  output logic signed [COORD_WIDTH-1:0]      out_y_out,
  output logic signed [COORD_WIDTH-1:0]      out_z_out
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + GUARD_BITS;
  localparam int SW = DW + 1;
  localparam int TW = TRIG_FRAC_BITS + 2;

  logic signed [W-1:0]        center_x_r;
  logic signed [W-1:0]        center_y_r;
  logic signed [W-1:0]        center_z_r;
  logic                       trig_busy;
  logic [TRIG_N-1:0][TW-1:0]  trig;

  logic                       v0_r;
  logic                       en0;
  logic                       in_accept;
  logic signed [DW-1:0]       dx0_r;
  logic signed [DW-1:0]       dy0_r;
  logic signed [DW-1:0]       dz0_r;

  logic                       rx_ready;
  logic                       rx_valid;
  logic signed [DW-1:0]       rx_dy;
  logic signed [DW-1:0]       rx_dz;
  logic signed [DW-1:0]       rx_dx;
  logic                       ry_ready;
  logic                       ry_valid;
  logic signed [DW-1:0]       ry_dz;
  logic signed [DW-1:0]       ry_dx;
  logic signed [DW-1:0]       ry_dy;
  logic                       rz_ready;
  logic                       rz_valid;
  logic signed [DW-1:0]       rz_dx;
  logic signed [DW-1:0]       rz_dy;
  logic signed [DW-1:0]       rz_dz;

  logic                       out_valid_r;
  logic                       enf;
  logic signed [W-1:0]        out_x_r;
  logic signed [W-1:0]        out_y_r;
  logic signed [W-1:0]        out_z_r;

  function automatic logic signed [W-1:0] sat_add(
    input logic signed [W-1:0]  c,
    input logic signed [DW-1:0] d
  );
    logic signed [SW-1:0] sum;
    logic signed [W-1:0]  res;
    sum = {{(SW-W){c[W-1]}}, c} + {d[DW-1], d};
    // fits when all bits from the output sign bit upward agree
    if ((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1])) begin
      res = sum[W-1:0];
    end else if (sum[SW-1]) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = {1'b0, {(W-1){1'b1}}};
    end
    return res;
  endfunction

  // center registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_CENTER_X) center_x_r <= cfg_wdata;
      if (cfg_index == REG_CENTER_Y) center_y_r <= cfg_wdata;
      if (cfg_index == REG_CENTER_Z) center_z_r <= cfg_wdata;
    end
  end

  erc_trig_unit #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_angle(cfg_wdata[ANGLE_W-1:0]),
    .busy     (trig_busy),
    .trig     (trig)
  );

  // offset from the center
  assign en0       = !v0_r || rx_ready;
  assign in_stall  = !en0 || trig_busy || cfg_we;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      dx0_r <= {{GUARD_BITS{in_x_in[W-1]}}, in_x_in}
               - {{GUARD_BITS{center_x_r[W-1]}}, center_x_r};
      dy0_r <= {{GUARD_BITS{in_y_in[W-1]}}, in_y_in}
               - {{GUARD_BITS{center_y_r[W-1]}}, center_y_r};
      dz0_r <= {{GUARD_BITS{in_z_in[W-1]}}, in_z_in}
               - {{GUARD_BITS{center_z_r[W-1]}}, center_z_r};
    end
  end

  // about x: (y, z)
  erc_rot_stage #(
    .DW(DW),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_ready (rx_ready),
    .p_i      (dy0_r),
    .q_i      (dz0_r),
    .side_i   (dx0_r),
    .c_i      (trig[TRIG_COS_X]),
    .s_i      (trig[TRIG_SIN_X]),
    .out_valid(rx_valid),
    .out_ready(ry_ready),
    .a_o      (rx_dy),
    .b_o      (rx_dz),
    .side_o   (rx_dx)
  );

  // about y: (z, x)
  erc_rot_stage #(
    .DW(DW),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rx_valid),
    .in_ready (ry_ready),
    .p_i      (rx_dz),
    .q_i      (rx_dx),
    .side_i   (rx_dy),
    .c_i      (trig[TRIG_COS_Y]),
    .s_i      (trig[TRIG_SIN_Y]),
    .out_valid(ry_valid),
    .out_ready(rz_ready),
    .a_o      (ry_dz),
    .b_o      (ry_dx),
    .side_o   (ry_dy)
  );

  // about z: (x, y)
  erc_rot_stage #(
    .DW(DW),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ry_valid),
    .in_ready (rz_ready),
    .p_i      (ry_dx),
    .q_i      (ry_dy),
    .side_i   (ry_dz),
    .c_i      (trig[TRIG_COS_Z]),
    .s_i      (trig[TRIG_SIN_Z]),
    .out_valid(rz_valid),
    .out_ready(enf),
    .a_o      (rz_dx),
    .b_o      (rz_dy),
    .side_o   (rz_dz)
  );

  // add the center back and saturate into the output register
  assign enf = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (enf) begin
      out_valid_r <= rz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enf) begin
      out_x_r <= sat_add(center_x_r, rz_dx);
      out_y_r <= sat_add(center_y_r, rz_dy);
      out_z_r <= sat_add(center_z_r, rz_dz);
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;
  assign out_z_out = out_z_r;

endmodule

`default_nettype wire

[hw/rtl/erc_trig_unit.sv]
// ----------------------------------------------------------------------------
// erc_trig_unit
// Holds the three angles and their cosines and sines. An angle write queues
// a sequencer that evaluates the sine series with one shared multiplier,
// dividing by the series constants through reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_trig_unit
  import erc_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 16,
  localparam int TW = TRIG_FRAC_BITS + 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ANGLE_W-1:0]         cfg_angle,
  output logic                            busy,
  output logic [TRIG_N-1:0][TW-1:0]       trig
);

  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic [31:0] RND   = 32'd1 << (SH - 1);
  localparam logic [31:0] ONE_F = 32'd1 << TRIG_FRAC_BITS;
  localparam logic [TW-1:0] COEF_ONE = TW'(1) << TRIG_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T,
    ST_T2,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_STORE
  } state_t;

  state_t               state_r;
  logic [ANGLE_W-1:0]   angle_r [3];
  logic [2:0]           pend_r;
  logic [1:0]           slot_r;
  logic                 eval_r;      // 0: cosine, 1: sine
  logic [ANGLE_W-1:0]   ang_r;
  logic [ANGLE_W-1:0]   base_r;
  logic [30:0]          t_r;
  logic [31:0]          t2_r;        // also holds the final series product
  logic [30:0]          h_r;
  logic [2:0]           step_r;
  logic [31:0]          div_r;
  logic [TW-1:0]        trig_r [TRIG_N];

  logic [2:0]           pend_set;
  logic [2:0]           pend_clr;
  logic [1:0]           sel;
  logic [14:0]          rq;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [31:0]          div_pre;
  logic [30:0]          quo;
  logic [31:0]          s_rnd;
  logic [31:0]          s_sh;
  logic [TW-1:0]        mag;
  logic [TW-1:0]        coef_nxt;

  always_comb begin
    pend_set = '0;
    if (cfg_we) begin
      pend_set[0] = (cfg_index == REG_ANGLE_X);
      pend_set[1] = (cfg_index == REG_ANGLE_Y);
      pend_set[2] = (cfg_index == REG_ANGLE_Z);
    end
  end

  always_comb begin
    if (pend_r[0]) begin
      sel = 2'd0;
    end else if (pend_r[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  always_comb begin
    pend_clr = '0;
    if (state_r == ST_IDLE && (|pend_r)) begin
      pend_clr[sel] = 1'b1;
    end
  end

  // fold the angle into the first quadrant
  assign rq = ang_r[14] ? (QUARTER - {1'b0, ang_r[13:0]}) : {1'b0, ang_r[13:0]};

  // divide by the series constant: strip its power of two, then reciprocal
  assign div_pre = div_r >> horner_pre_sh(step_r);

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_T: begin
        mul_a = {17'd0, rq};
        mul_b = PI_Q30;
      end
      ST_T2: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, t_r};
      end
      ST_MUL: begin
        mul_a = t2_r;
        mul_b = {1'b0, h_r};
      end
      ST_DIV: begin
        mul_a = div_pre;
        mul_b = horner_magic(step_r);
      end
      ST_FIN: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, h_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign quo = 31'(prod >> horner_post_sh(step_r));

  // round half up to the coefficient precision, clamp at one, apply sign
  always_comb begin
    s_rnd = {1'b0, t2_r[30:0]} + RND;
    s_sh  = s_rnd >> SH;
    if (s_sh > ONE_F) begin
      mag = COEF_ONE;
    end else begin
      mag = s_sh[TW-1:0];
    end
    coef_nxt = ang_r[15] ? TW'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        angle_r[i] <= '0;
      end
      for (int i = 0; i < TRIG_N; i += 2) begin
        trig_r[i]     <= COEF_ONE;
        trig_r[i + 1] <= '0;
      end
    end else begin
      pend_r <= (pend_r & ~pend_clr) | pend_set;
      if (pend_set[0]) angle_r[0] <= cfg_angle;
      if (pend_set[1]) angle_r[1] <= cfg_angle;
      if (pend_set[2]) angle_r[2] <= cfg_angle;

      case (state_r)
        ST_IDLE: begin
          if (|pend_r) begin
            slot_r  <= sel;
            eval_r  <= 1'b0;
            base_r  <= angle_r[sel];
            ang_r   <= angle_r[sel] + ANGLE_W'(QUARTER);
            state_r <= ST_T;
          end
        end
        ST_T: begin
          t_r     <= prod[45:15];
          state_r <= ST_T2;
        end
        ST_T2: begin
          t2_r    <= prod[61:30];
          h_r     <= Q30_ONE;
          step_r  <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          div_r   <= prod[61:30];
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          h_r <= Q30_ONE - quo;
          if (step_r == 3'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          t2_r    <= {1'b0, prod[60:30]};
          state_r <= ST_STORE;
        end
        ST_STORE: begin
          trig_r[{slot_r, eval_r}] <= coef_nxt;
          if (!eval_r) begin
            eval_r  <= 1'b1;
            ang_r   <= base_r;
            state_r <= ST_T;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE) || (|pend_r);

  always_comb begin
    for (int i = 0; i < TRIG_N; i++) begin
      trig[i] = trig_r[i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/erc_rot_stage.sv]
// ----------------------------------------------------------------------------
// erc_rot_stage
// One plane rotation: a = p*c - q*s, b = p*s + q*c, each rounded half up.
// A product register and a sum register; a third coordinate rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_rot_stage
  import erc_pkg::*;
#(
  parameter int DW = 36,
  parameter int TRIG_FRAC_BITS = 16,
  localparam int TW = TRIG_FRAC_BITS + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [DW-1:0] p_i,
  input  wire logic signed [DW-1:0] q_i,
  input  wire logic signed [DW-1:0] side_i,
  input  wire logic signed [TW-1:0] c_i,
  input  wire logic signed [TW-1:0] s_i,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DW-1:0]      a_o,
  output logic signed [DW-1:0]      b_o,
  output logic signed [DW-1:0]      side_o
);

  localparam int PW = DW + TW;
  localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (TRIG_FRAC_BITS - 1);

  logic                 v1_r;
  logic                 v2_r;
  logic                 en1;
  logic                 en2;
  logic signed [PW-1:0] pc_r;
  logic signed [PW-1:0] qs_r;
  logic signed [PW-1:0] ps_r;
  logic signed [PW-1:0] qc_r;
  logic signed [DW-1:0] side1_r;
  logic signed [PW:0]   a_nxt;
  logic signed [PW:0]   b_nxt;
  logic signed [DW-1:0] a_r;
  logic signed [DW-1:0] b_r;
  logic signed [DW-1:0] side2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pc_r    <= p_i * c_i;
      qs_r    <= q_i * s_i;
      ps_r    <= p_i * s_i;
      qc_r    <= q_i * c_i;
      side1_r <= side_i;
    end
  end

  assign a_nxt = pc_r - qs_r + HALF;
  assign b_nxt = ps_r + qc_r + HALF;

  always_ff @(posedge clk) begin
    if (en2) begin
      a_r     <= a_nxt[TRIG_FRAC_BITS+DW-1:TRIG_FRAC_BITS];
      b_r     <= b_nxt[TRIG_FRAC_BITS+DW-1:TRIG_FRAC_BITS];
      side2_r <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign a_o       = a_r;
  assign b_o       = b_r;
  assign side_o    = side2_r;

endmodule

`default_nettype wire
